// ===== hdl/skfu_pkg.sv =====
// Shared types, constants and arithmetic for the cross-kernel sharpen filter.
package skfu_pkg;

    localparam int MAX_ROW_BYTES_DEF = 16384;

    localparam int BYTE_W    = 8;
    localparam int ROW_W     = 12;
    localparam int IDX_W     = 14;
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 2;
    localparam int CH_W      = 3;
    localparam int RB_W      = 15;   // row length in bytes, up to 16384
    localparam int GAIN      = 5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_PIXELS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_ROWS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS     = 2'd2;

    localparam logic [CFG_W-1:0] WIDTH_RESET    = 13'd640;
    localparam logic [CFG_W-1:0] HEIGHT_RESET   = 13'd480;
    localparam logic [CH_W-1:0]  CHANNELS_RESET = 3'd3;
    localparam logic [CFG_W-1:0] DIM_MIN        = 13'd3;
    localparam logic [CFG_W-1:0] DIM_MAX        = 13'd4096;
    localparam logic [CH_W-1:0]  CH_MIN         = 3'd1;
    localparam logic [CH_W-1:0]  CH_MAX         = 3'd4;

    // frame geometry after clamping
    typedef struct packed {
        logic [CH_W-1:0]  ch;         // 1..4
        logic [CFG_W-1:0] h;          // 3..4096
        logic [RB_W-1:0]  row_bytes;  // w * ch
        logic [RB_W-1:0]  inner_end;  // (w - 1) * ch
    } skfu_geom_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic [ROW_W-1:0]  out_row;
        logic [IDX_W-1:0]  out_byte_index;
        logic              frame_end;
    } skfu_res_t;

    // 5*centre minus the four cross neighbours, saturated to a byte
    function automatic logic [BYTE_W-1:0] skfu_sharpen(
        input logic [BYTE_W-1:0] centre,
        input logic [BYTE_W-1:0] left,
        input logic [BYTE_W-1:0] right,
        input logic [BYTE_W-1:0] up,
        input logic [BYTE_W-1:0] down
    );
        logic [10:0]        gain;
        logic [9:0]         ring;
        logic signed [12:0] v;
        logic [BYTE_W-1:0]  q;
        gain = 11'(centre) * 11'(GAIN);
        ring = 10'(left) + 10'(right) + 10'(up) + 10'(down);
        v    = $signed({2'b00, gain}) - $signed({3'b000, ring});
        if (v < 13'sd0)
        begin
            q = '0;
        end
        else if (v > 13'sd255)
        begin
            q = '1;
        end
        else
        begin
            q = v[BYTE_W-1:0];
        end
        return q;
    endfunction

endpackage

// ===== hdl/skfu_if.sv =====
// Request channel interfaces: pixel input, result output and register writes.
interface skfu_in_if;
    import skfu_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] pixel_byte;
    modport source (output valid, output pixel_byte, input ready);
    modport sink   (input valid, input pixel_byte, output ready);
endinterface

interface skfu_out_if;
    import skfu_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic [ROW_W-1:0]  out_row;
    logic [IDX_W-1:0]  out_byte_index;
    logic              frame_end;
    modport source (output valid, output out_byte, output out_row,
                    output out_byte_index, output frame_end, input ready);
    modport sink   (input valid, input out_byte, input out_row,
                    input out_byte_index, input frame_end, output ready);
endinterface

interface skfu_cfg_if;
    import skfu_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/skfu_cfg.sv =====
// Configuration registers and clamped frame geometry.
module skfu_cfg #(
    parameter int MAX_ROW_BYTES = skfu_pkg::MAX_ROW_BYTES_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    skfu_cfg_if.sink               cfg,
    output skfu_pkg::skfu_geom_t   geom,
    output logic                   settling
);
    import skfu_pkg::*;

    localparam int LIM_W = $clog2(MAX_ROW_BYTES + 1);
    localparam int LIM1  = MAX_ROW_BYTES / 1;
    localparam int LIM2  = MAX_ROW_BYTES / 2;
    localparam int LIM3  = MAX_ROW_BYTES / 3;
    localparam int LIM4  = MAX_ROW_BYTES / 4;

    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    logic [CH_W-1:0]  channels_reg;
    logic             settle_reg;
    skfu_geom_t       geom_reg;
    skfu_geom_t       geom_next;

    logic [CH_W-1:0]  ch_c;
    logic [CFG_W-1:0] w_c;
    logic [CFG_W-1:0] h_c;
    logic [LIM_W-1:0] w_lim;
    logic [CFG_W-1:0] w_e;
    logic             wr;

    assign cfg.ready = 1'b1;
    assign wr        = cfg.valid && cfg.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= WIDTH_RESET;
            height_reg   <= HEIGHT_RESET;
            channels_reg <= CHANNELS_RESET;
            settle_reg   <= 1'b1;
        end
        else
        begin
            settle_reg <= wr;
            if (wr)
            begin
                case (cfg.index)
                    CFG_WIDTH_PIXELS: width_reg    <= cfg.data;
                    CFG_HEIGHT_ROWS:  height_reg   <= cfg.data;
                    CFG_CHANNELS:     channels_reg <= cfg.data[CH_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_comb
    begin
        ch_c = (channels_reg < CH_MIN) ? CH_MIN :
               (channels_reg > CH_MAX) ? CH_MAX : channels_reg;
        w_c  = (width_reg < DIM_MIN) ? DIM_MIN :
               (width_reg > DIM_MAX) ? DIM_MAX : width_reg;
        h_c  = (height_reg < DIM_MIN) ? DIM_MIN :
               (height_reg > DIM_MAX) ? DIM_MAX : height_reg;
        case (ch_c)
            3'd1:    w_lim = LIM_W'(LIM1);
            3'd2:    w_lim = LIM_W'(LIM2);
            3'd3:    w_lim = LIM_W'(LIM3);
            default: w_lim = LIM_W'(LIM4);
        endcase
        // row must fit in the row store
        if (32'(w_c) > 32'(w_lim))
        begin
            w_e = CFG_W'(w_lim);
        end
        else
        begin
            w_e = w_c;
        end
        geom_next.ch        = ch_c;
        geom_next.h         = h_c;
        geom_next.row_bytes = RB_W'(w_e) * RB_W'(ch_c);
        geom_next.inner_end = RB_W'(w_e - 13'd1) * RB_W'(ch_c);
    end

    always_ff @(posedge clk)
    begin
        geom_reg <= geom_next;
    end

    assign geom     = geom_reg;
    assign settling = settle_reg;

endmodule

// ===== hdl/skfu_row_mem.sv =====
// Row store: {two rows above, one row above} per byte, two read ports, one write.
module skfu_row_mem #(
    parameter int MAX_ROW_BYTES = skfu_pkg::MAX_ROW_BYTES_DEF,
    parameter int ADDR_W        = $clog2(MAX_ROW_BYTES)
) (
    input  logic                        clk,
    input  logic                        rd_en,
    input  logic [ADDR_W-1:0]           rd_addr_a,
    input  logic [ADDR_W-1:0]           rd_addr_b,
    output logic [2*skfu_pkg::BYTE_W-1:0] rd_data_a,
    output logic [skfu_pkg::BYTE_W-1:0] rd_data_b,
    input  logic                        wr_en,
    input  logic [ADDR_W-1:0]           wr_addr,
    input  logic [2*skfu_pkg::BYTE_W-1:0] wr_data
);
    import skfu_pkg::*;

    logic [2*BYTE_W-1:0] mem [MAX_ROW_BYTES];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b][BYTE_W-1:0];
        end
    end

endmodule

// ===== hdl/skfu_out_buf.sv =====
// Two-slot result register: sharpened byte of the row above, then the copied byte.
module skfu_out_buf (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  logic                 a_valid,
    input  skfu_pkg::skfu_res_t  a_res,
    input  logic                 b_valid,
    input  skfu_pkg::skfu_res_t  b_res,
    output logic                 free,
    skfu_out_if.source           res
);
    import skfu_pkg::*;

    logic      a_valid_reg;
    logic      b_valid_reg;
    skfu_res_t a_reg;
    skfu_res_t b_reg;
    skfu_res_t shown;
    logic      taken;

    assign taken = res.valid && res.ready;
    // free when empty or the last pending request leaves now
    assign free  = !(a_valid_reg || b_valid_reg) ||
                   (res.ready && (a_valid_reg ^ b_valid_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            a_valid_reg <= a_valid;
            b_valid_reg <= b_valid;
        end
        else if (taken)
        begin
            if (a_valid_reg)
            begin
                a_valid_reg <= 1'b0;
            end
            else
            begin
                b_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            a_reg <= a_res;
            b_reg <= b_res;
        end
    end

    assign shown              = a_valid_reg ? a_reg : b_reg;
    assign res.valid          = a_valid_reg || b_valid_reg;
    assign res.out_byte       = shown.out_byte;
    assign res.out_row        = shown.out_row;
    assign res.out_byte_index = shown.out_byte_index;
    assign res.frame_end      = shown.frame_end;

endmodule

// ===== hdl/cross_kernel_sharpen_filter_unit.sv =====
// Top level of the streaming 3x3 cross sharpen filter.
//
// Usage:
//   pix carries one image byte per request, raster order, channels of a
//   pixel interleaved. res returns result requests: the byte, its row, its
//   byte index and frame_end on the last one of a frame. cfg writes
//   width_pixels (0), height_rows (1) and channels (2); write only when idle.
// Timing:
//   A byte at (row r, index b) releases the result for (r-1, b) via the
//   compute stage and result register. Row 0 gives no result; the last
//   row gives two requests per byte (sharpened byte above, then the byte
//   itself). Sustained rate is one byte per cycle while the receiver is
//   ready; on the last row both requests share the single result port.
//   The row store is read at the byte and its right neighbor on accept
//   and written back as the byte leaves the compute stage.
// Reset and stalls:
//   Reset restores 640x480x3 and zeroes the positions; pix.ready stays low
//   after reset and after each register write while the geometry is
//   recomputed. A stalled receiver holds the result register, which
//   stalls the compute stage and then pix.ready; nothing is dropped.
module cross_kernel_sharpen_filter_unit #(
    parameter int MAX_ROW_BYTES = skfu_pkg::MAX_ROW_BYTES_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    skfu_cfg_if.sink   cfg,
    skfu_in_if.sink    pix,
    skfu_out_if.source res
);
    import skfu_pkg::*;

    localparam int ADDR_W = $clog2(MAX_ROW_BYTES);
    localparam int CW     = (ADDR_W > RB_W) ? ADDR_W + 1 : RB_W + 1;

    skfu_geom_t geom;
    logic       settling;

    // input side position counters
    logic [ADDR_W-1:0] byte_pos_reg;
    logic [ADDR_W-1:0] byte_pos_next;
    logic [ROW_W-1:0]  row_pos_reg;
    logic [ROW_W-1:0]  row_pos_next;

    logic [ADDR_W-1:0] b_now;
    logic [ROW_W-1:0]  r_now;
    logic              b_last;
    logic              r_last;
    logic              interior;
    logic              in_fire;

    // compute stage
    logic              s1_valid_reg;
    logic [BYTE_W-1:0] s1_x_reg;
    logic [ADDR_W-1:0] s1_b_reg;
    logic [ROW_W-1:0]  s1_r_reg;
    logic              s1_has_a_reg;
    logic              s1_int_reg;
    logic              s1_last_row_reg;
    logic              s1_fend_reg;
    logic              s1_fire;
    logic              out_free;

    logic [2*BYTE_W-1:0] rd_cur;
    logic [BYTE_W-1:0]   rd_right;
    logic [BYTE_W-1:0]   centre;
    logic [BYTE_W-1:0]   up;
    logic [BYTE_W-1:0]   left;
    logic [1:0]          left_sel;
    logic [BYTE_W-1:0]   left_sh_reg [4];
    logic [ADDR_W-1:0]   rd_addr_right;

    skfu_res_t res_a;
    skfu_res_t res_b;

    skfu_cfg #(
        .MAX_ROW_BYTES (MAX_ROW_BYTES)
    ) u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .geom     (geom),
        .settling (settling)
    );

    // ---- accept side: wrap positions, classify the byte ----
    always_comb
    begin
        b_now = (CW'(byte_pos_reg) >= CW'(geom.row_bytes)) ? '0 : byte_pos_reg;
        r_now = (CFG_W'(row_pos_reg) >= geom.h) ? '0 : row_pos_reg;
        b_last = (CW'(b_now) + CW'(1)) >= CW'(geom.row_bytes);
        r_last = (CFG_W'(r_now) + CFG_W'(1)) >= geom.h;
        // interior: third row on, away from the leftmost and rightmost pixel
        interior = (r_now >= ROW_W'(2)) &&
                   (CW'(b_now) >= CW'(geom.ch)) &&
                   (CW'(b_now) < CW'(geom.inner_end));
        if (b_last)
        begin
            byte_pos_next = '0;
            row_pos_next  = r_last ? '0 : r_now + ROW_W'(1);
        end
        else
        begin
            byte_pos_next = b_now + ADDR_W'(1);
            row_pos_next  = r_now;
        end
        rd_addr_right = ADDR_W'(CW'(b_now) + CW'(geom.ch));
    end

    assign pix.ready = !settling && (!s1_valid_reg || s1_fire);
    assign in_fire   = pix.valid && pix.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_pos_reg <= '0;
            row_pos_reg  <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                byte_pos_reg <= byte_pos_next;
                row_pos_reg  <= row_pos_next;
                s1_valid_reg <= 1'b1;
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_x_reg        <= pix.pixel_byte;
            s1_b_reg        <= b_now;
            s1_r_reg        <= r_now;
            s1_has_a_reg    <= (r_now != '0);
            s1_int_reg      <= interior;
            s1_last_row_reg <= r_last;
            s1_fend_reg     <= r_last && b_last;
        end
    end

    // ---- row store: read at accept, write back as the byte leaves ----
    skfu_row_mem #(
        .MAX_ROW_BYTES (MAX_ROW_BYTES),
        .ADDR_W        (ADDR_W)
    ) u_row_mem (
        .clk       (clk),
        .rd_en     (in_fire),
        .rd_addr_a (b_now),
        .rd_addr_b (rd_addr_right),
        .rd_data_a (rd_cur),
        .rd_data_b (rd_right),
        .wr_en     (s1_fire),
        .wr_addr   (s1_b_reg),
        .wr_data   ({centre, s1_x_reg})
    );

    // ---- compute stage ----
    assign centre   = rd_cur[BYTE_W-1:0];
    assign up       = rd_cur[2*BYTE_W-1:BYTE_W];
    assign left_sel = 2'(geom.ch - CH_W'(1));
    assign left     = left_sh_reg[left_sel];   // centre read ch bytes ago
    assign s1_fire  = s1_valid_reg && out_free;

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            left_sh_reg[0] <= centre;
            left_sh_reg[1] <= left_sh_reg[0];
            left_sh_reg[2] <= left_sh_reg[1];
            left_sh_reg[3] <= left_sh_reg[2];
        end
    end

    always_comb
    begin
        res_a.out_byte       = s1_int_reg ?
                               skfu_sharpen(centre, left, rd_right, up, s1_x_reg) : centre;
        res_a.out_row        = s1_r_reg - ROW_W'(1);
        res_a.out_byte_index = IDX_W'(s1_b_reg);
        res_a.frame_end      = 1'b0;
        res_b.out_byte       = s1_x_reg;
        res_b.out_row        = s1_r_reg;
        res_b.out_byte_index = IDX_W'(s1_b_reg);
        res_b.frame_end      = s1_fend_reg;
    end

    skfu_out_buf u_out_buf (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (s1_fire),
        .a_valid (s1_has_a_reg),
        .a_res   (res_a),
        .b_valid (s1_last_row_reg),
        .b_res   (res_b),
        .free    (out_free),
        .res     (res)
    );

    // ---- checks ----
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !out_free |-> !pix.ready)
        else $error("input taken while compute stage is stalled");

    a_frame_wraps: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && r_last && b_last |=> byte_pos_reg == '0 && row_pos_reg == '0)
        else $error("positions not cleared after last byte of frame");

    a_no_same_entry: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && s1_fire |-> b_now != s1_b_reg)
        else $error("row store read and write hit the same entry");

    a_cfg_settles: assert property (@(posedge clk) disable iff (!rst_n)
        cfg.valid && cfg.ready |=> !pix.ready)
        else $error("input taken before geometry settled");

endmodule
